>>> rtl/core/dib32l_pkg.sv
// Shared types, constants and the symbol alphabet of the base32 identifier encoder.
package dib32l_pkg;

   localparam int SYMS_PER_ITEM = 3;

   localparam logic [4:0] LAST_BYTE  = 5'd31;
   localparam logic [3:0] CHUNK_LEN  = 4'd13;
   localparam logic [2:0] GROUP_LAST = 3'd6;
   localparam logic [6:0] CHAR_DASH  = 7'h2D;
   localparam logic [6:0] CHAR_A     = 7'h41;
   localparam logic [6:0] CHAR_TWO   = 7'h32;
   localparam logic [4:0] DIGIT_BASE = 5'd26;

   typedef struct packed {
      logic [SYMS_PER_ITEM-1:0][4:0] syms;
      logic [1:0]                    count;
      logic                          last_byte;
   } sym_entry_type;

   function automatic logic [6:0] sym_char(input logic [4:0] v);
      logic [4:0] d;
      d = v - DIGIT_BASE;
      if (v < DIGIT_BASE) begin
         sym_char = CHAR_A + {2'b00, v};
      end else begin
         sym_char = CHAR_TWO + {2'b00, d};
      end
   endfunction

endpackage

>>> rtl/core/dib32l_front.sv
// Front end: takes hash bytes and slices them into base32 data symbols.
module dib32l_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_hash_byte,
   output logic                      push_valid,
   input  logic                      push_ready,
   output dib32l_pkg::sym_entry_type push_entry
);
   import dib32l_pkg::*;

   logic [4:0]  byte_count_ff, byte_count_in;
   logic [3:0]  left_bits_ff, left_bits_in;
   logic [2:0]  left_count_ff, left_count_in;

   logic [3:0]  cnt_base;
   logic [3:0]  cnt;
   logic [11:0] acc;
   logic        two;
   logic        final_byte;
   logic [4:0]  sym0;
   logic [4:0]  sym1;
   logic [3:0]  rem;
   logic [11:0] keep;
   logic [4:0]  flush_sym;
   logic        flush;
   logic        take;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid && push_ready;

   always_comb begin
      cnt_base   = (left_count_ff > 3'd4) ? 4'd4 : {1'b0, left_count_ff};
      cnt        = cnt_base + 4'd8;
      acc        = {left_bits_ff, req_hash_byte};
      two        = (cnt >= 4'd10);
      final_byte = (byte_count_ff == LAST_BYTE);
      sym0       = 5'(acc >> (cnt - 4'd5));
      sym1       = 5'(acc >> (cnt - 4'd10));
      rem        = two ? (cnt - 4'd10) : (cnt - 4'd5);
      keep       = acc & ((12'd1 << rem) - 12'd1);
      flush_sym  = {1'b0, keep[3:0]} << (4'd5 - rem);
      flush      = final_byte && (rem != 4'd0);

      push_entry.syms[0]   = sym0;
      push_entry.syms[1]   = two ? sym1 : flush_sym;
      push_entry.syms[2]   = flush_sym;
      push_entry.count     = (two ? 2'd2 : 2'd1) + {1'b0, flush};
      push_entry.last_byte = final_byte;

      if (final_byte) begin
         byte_count_in = 5'd0;
         left_bits_in  = 4'd0;
         left_count_in = 3'd0;
      end else begin
         byte_count_in = byte_count_ff + 5'd1;
         left_bits_in  = keep[3:0];
         left_count_in = rem[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 5'd0;
         left_bits_ff  <= 4'd0;
         left_count_ff <= 3'd0;
      end else if (take) begin
         byte_count_ff <= byte_count_in;
         left_bits_ff  <= left_bits_in;
         left_count_ff <= left_count_in;
      end
   end

endmodule

>>> rtl/core/dib32l_queue.sv
// Small register queue that decouples the symbol slicer from the character emitter.
module dib32l_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  dib32l_pkg::sym_entry_type in_entry,
   output logic                      out_valid,
   input  logic                      out_ready,
   output dib32l_pkg::sym_entry_type out_entry
);
   import dib32l_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sym_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push;
   logic             pop;

   assign in_ready  = (fill_ff != CNT_FULL);
   assign out_valid = (fill_ff != '0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

>>> rtl/core/dib32l_back.sv
// Back end: Luhn check insertion, grouping and character output buffer.
module dib32l_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  dib32l_pkg::sym_entry_type pop_entry,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [6:0]                rsp_char_code,
   output logic                      rsp_last_of_id,
   output logic                      rsp_last_of_item
);
   import dib32l_pkg::*;

   logic             weight_ff, weight_in;
   logic [4:0]       sum_ff, sum_in;
   logic [3:0]       pos_ff, pos_in;
   logic [2:0]       grp_ff, grp_in;
   logic             started_ff, started_in;

   logic             buf_valid_ff;
   logic [3:0][6:0]  chars_ff, chars_in;
   logic [2:0]       count_ff, count_in;
   logic [1:0]       idx_ff;
   logic             final_ff;

   logic [4:0]       v;
   logic [5:0]       p;
   logic [4:0]       ck;
   logic             is_last;
   logic             load;

   assign is_last          = ({1'b0, idx_ff} == (count_ff - 3'd1));
   assign load             = pop_valid && (!buf_valid_ff || (rsp_ready && is_last));
   assign pop_ready        = !buf_valid_ff || (rsp_ready && is_last);
   assign rsp_valid        = buf_valid_ff;
   assign rsp_char_code    = chars_ff[idx_ff];
   assign rsp_last_of_item = is_last;
   assign rsp_last_of_id   = is_last && final_ff;

   always_comb begin
      weight_in  = weight_ff;
      sum_in     = sum_ff;
      pos_in     = pos_ff;
      grp_in     = grp_ff;
      started_in = started_ff;
      chars_in   = '0;
      count_in   = 3'd0;
      v          = 5'd0;
      p          = 6'd0;
      ck         = 5'd0;
      for (int i = 0; i < SYMS_PER_ITEM; i++) begin
         if (2'(i) < pop_entry.count) begin
            v = pop_entry.syms[i];
            if (started_in && grp_in == 3'd0 && count_in < 3'd4) begin
               chars_in[count_in[1:0]] = CHAR_DASH;
               count_in = count_in + 3'd1;
            end
            if (count_in < 3'd4) begin
               chars_in[count_in[1:0]] = sym_char(v);
               count_in = count_in + 3'd1;
            end
            started_in = 1'b1;
            grp_in     = (grp_in == GROUP_LAST) ? 3'd0 : grp_in + 3'd1;
            p          = weight_in ? {v, 1'b0} : {1'b0, v};
            sum_in     = sum_in + {4'd0, p[5]} + p[4:0];
            weight_in  = ~weight_in;
            pos_in     = pos_in + 4'd1;
            if (pos_in >= CHUNK_LEN) begin
               ck = 5'd0 - sum_in;
               if (grp_in == 3'd0 && count_in < 3'd4) begin
                  chars_in[count_in[1:0]] = CHAR_DASH;
                  count_in = count_in + 3'd1;
               end
               if (count_in < 3'd4) begin
                  chars_in[count_in[1:0]] = sym_char(ck);
                  count_in = count_in + 3'd1;
               end
               grp_in    = (grp_in == GROUP_LAST) ? 3'd0 : grp_in + 3'd1;
               pos_in    = 4'd0;
               weight_in = 1'b0;
               sum_in    = 5'd0;
            end
         end
      end
      if (pop_entry.last_byte) begin
         weight_in  = 1'b0;
         sum_in     = 5'd0;
         pos_in     = 4'd0;
         grp_in     = 3'd0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= 1'b0;
         sum_ff       <= 5'd0;
         pos_ff       <= 4'd0;
         grp_ff       <= 3'd0;
         started_ff   <= 1'b0;
         buf_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         if (load) begin
            weight_ff    <= weight_in;
            sum_ff       <= sum_in;
            pos_ff       <= pos_in;
            grp_ff       <= grp_in;
            started_ff   <= started_in;
            buf_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (buf_valid_ff && rsp_ready) begin
            if (is_last) begin
               buf_valid_ff <= 1'b0;
            end
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         chars_ff <= chars_in;
         count_ff <= count_in;
         final_ff <= pop_entry.last_byte;
      end
   end

endmodule

>>> rtl/core/device_id_base32_luhn_encoder_core.sv
// Top level of the base32 device identifier encoder with Luhn check symbols.
// Each request carries one byte of a 32-byte hash, most significant byte first, and
// yields one to four ASCII characters on the response channel, one character per
// cycle while rsp_ready is held high; the whole identifier is 63 characters for 32
// requests. The front slices bytes into symbols, a queue of QUEUE_DEPTH entries holds
// them, and the back inserts check symbols and separators, so requests keep being
// taken while responses wait, until the queue is full.
module device_id_base32_luhn_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_hash_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_char_code,
   output logic       rsp_last_of_id,
   output logic       rsp_last_of_item
);
   import dib32l_pkg::*;

   logic          push_valid;
   logic          push_ready;
   sym_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   sym_entry_type pop_entry;

   dib32l_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_hash_byte (req_hash_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   dib32l_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   dib32l_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_code    (rsp_char_code),
      .rsp_last_of_id   (rsp_last_of_id),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

>>> test/device_id_base32_luhn_encoder_core_test.sv
// Self-checking testbench for the base32 device identifier encoder with Luhn check symbols.
`timescale 1ns / 1ps

module device_id_base32_luhn_encoder_core_test;

   localparam logic [4:0] LAST_POS       = 5'd31;
   localparam logic [3:0] CHUNK_SYMS     = 4'd13;
   localparam int         GROUP_SYMS     = 7;
   localparam int         MAX_CHARS      = 4;
   localparam logic [4:0] DIGIT_START    = 5'd26;
   localparam logic [6:0] CHAR_SEP       = 7'h2D;
   localparam logic [6:0] CHAR_A_CODE    = 7'h41;
   localparam logic [6:0] CHAR_2_CODE    = 7'h32;
   localparam int         TIMEOUT_CYCLES = 200000;
   localparam int         STALL_CYCLES   = 150;
   localparam int         DRAIN_CYCLES   = 20;
   localparam int         REPORT_LIMIT   = 20;
   localparam int         ID_BYTES       = 32;

   typedef struct {
      logic [6:0] code;
      logic       last_id;
      logic       last_item;
   } char_expect_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_hash_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_char_code;
   logic       rsp_last_of_id;
   logic       rsp_last_of_item;

   logic [4:0] byte_pos = '0;
   logic [3:0] spare_bits = '0;
   logic [2:0] spare_count = '0;
   logic       double_next = 1'b0;
   logic [4:0] chunk_sum = '0;
   logic [3:0] chunk_len = '0;
   logic [5:0] sym_count = '0;

   char_expect_type pending_chars[$];
   char_expect_type byte_chars[$];
   char_expect_type want;

   int  mismatches = 0;
   int  cycle_count = 0;
   int  req_idle_pct = 8;
   int  rsp_idle_pct = 8;
   logic hold_rsp = 1'b0;

   device_id_base32_luhn_encoder_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_hash_byte(req_hash_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last_of_id(rsp_last_of_id),
      .rsp_last_of_item(rsp_last_of_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [6:0] symbol_ascii(input logic [4:0] sym);
      if (sym < DIGIT_START) begin
         return CHAR_A_CODE + {2'b00, sym};
      end
      return CHAR_2_CODE + {2'b00, sym - DIGIT_START};
   endfunction

   task automatic add_char(input logic [6:0] code);
      char_expect_type c;
      c.code = code;
      c.last_id = 1'b0;
      c.last_item = 1'b0;
      if (byte_chars.size() < MAX_CHARS) begin
         byte_chars.push_back(c);
      end
   endtask

   task automatic add_symbol(input logic [4:0] sym);
      if (sym_count != 0 && (sym_count % GROUP_SYMS) == 0) begin
         add_char(CHAR_SEP);
      end
      add_char(symbol_ascii(sym));
      sym_count = sym_count + 6'd1;
   endtask

   task automatic add_data(input logic [4:0] sym);
      logic [5:0] product;
      add_symbol(sym);
      product = double_next ? {sym, 1'b0} : {1'b0, sym};
      double_next = !double_next;
      chunk_sum = chunk_sum + {4'd0, product[5]} + product[4:0];
      chunk_len = chunk_len + 4'd1;
      if (chunk_len >= CHUNK_SYMS) begin
         add_symbol(5'd0 - chunk_sum);
         chunk_len = '0;
         double_next = 1'b0;
         chunk_sum = '0;
      end
   endtask

   task automatic encode_byte(input logic [7:0] value);
      logic [11:0] bits;
      logic [11:0] shifted;
      int          remain;
      byte_chars.delete();
      remain = (spare_count > 3'd4) ? 4 : int'(spare_count);
      bits = {spare_bits, value};
      remain = remain + 8;
      while (remain >= 5) begin
         shifted = bits >> (remain - 5);
         add_data(shifted[4:0]);
         remain = remain - 5;
      end
      bits = bits & ((12'd1 << remain) - 12'd1);
      spare_bits = bits[3:0];
      spare_count = 3'(remain);
      if (byte_pos == LAST_POS) begin
         if (remain > 0) begin
            shifted = bits << (5 - remain);
            add_data(shifted[4:0]);
         end
         byte_chars[byte_chars.size() - 1].last_id = 1'b1;
         byte_pos = '0;
         spare_bits = '0;
         spare_count = '0;
         double_next = 1'b0;
         chunk_sum = '0;
         chunk_len = '0;
         sym_count = '0;
      end else begin
         byte_pos = byte_pos + 5'd1;
      end
      byte_chars[byte_chars.size() - 1].last_item = 1'b1;
      foreach (byte_chars[i]) begin
         pending_chars.push_back(byte_chars[i]);
      end
   endtask

   task automatic report(input string msg);
      if (mismatches < REPORT_LIMIT) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            encode_byte(req_hash_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_chars.size() == 0) begin
               report($sformatf("unexpected response char 0x%02h", rsp_char_code));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_char_code !== want.code) begin
                  report($sformatf("char_code 0x%02h, want 0x%02h", rsp_char_code, want.code));
               end
               if (rsp_last_of_id !== want.last_id) begin
                  report($sformatf("last_of_id %b, want %b", rsp_last_of_id, want.last_id));
               end
               if (rsp_last_of_item !== want.last_item) begin
                  report($sformatf("last_of_item %b, want %b", rsp_last_of_item,
                                   want.last_item));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("device_id_base32_luhn_encoder_core regression: fail");
         $finish;
      end
   end

   task automatic send_hash_byte(input logic [7:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hash_byte <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_bytes(input int count);
      for (int i = 0; i < count; i++) begin
         send_hash_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic test_extreme_bytes;
      req_idle_pct = 8;
      rsp_idle_pct = 8;
      for (int i = 0; i < 4; i++) begin
         send_hash_byte(8'h00);
      end
      for (int i = 0; i < 4; i++) begin
         send_hash_byte(8'hFF);
      end
      for (int i = 0; i < 8; i++) begin
         send_hash_byte(8'h80 >> i);
      end
      for (int i = 0; i < 8; i++) begin
         send_hash_byte(~(8'h80 >> i));
      end
   endtask

   // Completes the first identifier; the last byte leaves a set bit for the padded symbol.
   task automatic test_identifier_end;
      for (int i = 0; i < 7; i++) begin
         send_hash_byte(i[0] ? 8'h55 : 8'hAA);
      end
      send_hash_byte(8'hFF);
   endtask

   task automatic test_random_identifiers;
      req_idle_pct = 8;
      rsp_idle_pct = 8;
      send_random_bytes(5 * ID_BYTES);
   endtask

   task automatic test_back_to_back;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random_bytes(2 * ID_BYTES);
   endtask

   task automatic test_output_stall;
      req_idle_pct = 0;
      rsp_idle_pct = 8;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (STALL_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         send_random_bytes(ID_BYTES);
      join
   endtask

   task automatic test_random_tail;
      req_idle_pct = 8;
      rsp_idle_pct = 8;
      send_random_bytes(ID_BYTES + 5);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_bytes();
      test_identifier_end();
      test_random_identifiers();
      test_back_to_back();
      test_output_stall();
      test_random_tail();
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("device_id_base32_luhn_encoder_core regression: pass");
      end else begin
         $display("device_id_base32_luhn_encoder_core regression: fail");
      end
      $finish;
   end

endmodule
